// ----- design/hfcv_pkg.sv -----
// Package for the hex frame checksum verifier.
// Holds the frame layout constants, the shared types and the hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package hfcv_pkg;

  // Frame layout, in bytes
  localparam int ADDR_BYTES      = 7;
  localparam int HDR_BYTES       = 1 + 2 * ADDR_BYTES + 2;
  localparam int TRAILER_BYTES   = 3;
  localparam int MIN_BYTES       = HDR_BYTES + TRAILER_BYTES;
  localparam int INFO_CAP_DEFAULT = 128;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FLAG    = 1'b0,
    CFG_CONTROL = 1'b1
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic [7:0] FLAG_RESET    = 8'd126;
  localparam logic [7:0] CONTROL_RESET = 8'd3;

  // Configuration seen by the frame core
  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] control_value;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [7:0] info_length;
    logic [7:0] pid_byte;
    logic       frame_ok;
  } result_t;

  // Decode one ASCII character: bit 4 is set when it is not a hex digit.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage

// ----- design/hfcv_frame_core.sv -----
// Frame state of the hex frame checksum verifier: digit pairing, the trailer
// delay line, the running sum and the end-of-frame check.
// Depends on hfcv_pkg.
`timescale 1ns / 1ps

module hfcv_frame_core
  import hfcv_pkg::*;
#(
  parameter int INFO_CAP = INFO_CAP_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] hex_char,
  input  logic       last_char,
  output result_t    result
);

  localparam logic [7:0] SUM_END   = 8'(HDR_BYTES + INFO_CAP);
  localparam logic [7:0] ADDR_END  = 8'(2 * ADDR_BYTES);
  localparam logic [7:0] CTRL_IDX  = 8'(2 * ADDR_BYTES + 1);
  localparam logic [7:0] PID_IDX   = 8'(2 * ADDR_BYTES + 2);
  localparam logic [7:0] MIN_COUNT = 8'(MIN_BYTES);
  localparam logic [7:0] CAP       = 8'(INFO_CAP);

  logic [4:0]  high_nibble;
  logic        pair_phase;
  logic [8:0]  byte_delay [TRAILER_BYTES];
  logic [7:0]  byte_count;
  logic [15:0] running_sum;
  logic        error_seen;
  logic [7:0]  held_pid;

  logic [4:0]  digit;
  logic [8:0]  entry;
  logic [7:0]  idx;
  logic [7:0]  out_byte;
  logic        out_bad;
  logic [7:0]  byte_count_next;
  logic [15:0] running_sum_next;
  logic        error_seen_next;
  logic [7:0]  held_pid_next;
  logic [15:0] want;
  logic [15:0] got;
  logic [7:0]  info;
  logic        ok;

  assign digit    = digit_value(hex_char);
  assign entry    = {high_nibble[4] | digit[4], high_nibble[3:0], digit[3:0]};
  assign idx      = byte_count - 8'(TRAILER_BYTES);
  assign out_byte = byte_delay[0][7:0];
  assign out_bad  = byte_delay[0][8];

  // Byte leaving the delay line: check it and add it in by its position
  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    error_seen_next  = error_seen;
    held_pid_next    = held_pid;
    if (pair_phase) begin
      if (byte_count != 8'hFF) begin
        byte_count_next = byte_count + 8'd1;
      end
      if (byte_count >= 8'(TRAILER_BYTES)) begin
        if (idx == 8'd0) begin
          if (out_bad || out_byte != cfg.flag_value) begin
            error_seen_next = 1'b1;
          end
        end else if (idx <= ADDR_END) begin
          error_seen_next  = error_seen | out_bad;
          running_sum_next = running_sum + {8'd0, out_byte};
        end else if (idx == CTRL_IDX) begin
          error_seen_next = error_seen | out_bad;
        end else if (idx == PID_IDX) begin
          error_seen_next  = error_seen | out_bad;
          held_pid_next    = out_byte;
          running_sum_next = running_sum + {8'd0, out_byte};
        end else if (idx < SUM_END) begin
          error_seen_next  = error_seen | out_bad;
          running_sum_next = running_sum + {8'd0, out_byte};
        end
      end
    end
  end

  // End-of-frame check; after a push the checksum sits in the two older
  // delay entries, which are the current entries one and two
  always_comb begin
    want = running_sum_next + {8'd0, cfg.control_value};
    got  = {byte_delay[1][7:0], byte_delay[2][7:0]};
    ok   = pair_phase && !error_seen_next && byte_count_next >= MIN_COUNT &&
           !byte_delay[1][8] && !byte_delay[2][8] && got == want;
    info = byte_count_next - MIN_COUNT;
    if (info > CAP) begin
      info = CAP;
    end
    result.frame_ok    = ok;
    result.pid_byte    = ok ? held_pid_next : 8'd0;
    result.info_length = ok ? info : 8'd0;
  end

  // Frame state; everything returns to reset after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase  <= 1'b0;
      byte_count  <= 8'd0;
      running_sum <= 16'd0;
      error_seen  <= 1'b0;
      held_pid    <= 8'd0;
    end else if (accept) begin
      if (last_char) begin
        pair_phase  <= 1'b0;
        byte_count  <= 8'd0;
        running_sum <= 16'd0;
        error_seen  <= 1'b0;
        held_pid    <= 8'd0;
      end else begin
        pair_phase  <= ~pair_phase;
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        error_seen  <= error_seen_next;
        held_pid    <= held_pid_next;
      end
    end
  end

  // Held digit and delay line; their contents count only as byte_count says
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!pair_phase) begin
        high_nibble <= digit;
      end else begin
        byte_delay[0] <= byte_delay[1];
        byte_delay[1] <= byte_delay[2];
        byte_delay[2] <= entry;
      end
    end
  end

endmodule

// ----- design/hex_frame_checksum_verifier.sv -----
// Top level of the hex frame checksum verifier: stream ports, configuration
// registers and the result register. Depends on hfcv_pkg and hfcv_frame_core.
// The result of a frame is registered and shown in the cycle after its last character.
// Throughput: one character per cycle; the only stall is a held result word.
// Reset (rst, synchronous) clears the frame state and the result valid flag and
// sets flag_value to 126 and control_value to 3.
`timescale 1ns / 1ps

module hex_frame_checksum_verifier
  import hfcv_pkg::*;
#(
  parameter int INFO_CAP = INFO_CAP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Character stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] hex_char
  input  logic        s_tlast,   // last_char
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] frame_ok, [8:1] pid_byte, [16:9] info_length
);

  cfg_t    cfg;
  result_t result;
  result_t out_word;
  logic    accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value    <= FLAG_RESET;
      cfg.control_value <= CONTROL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FLAG:    cfg.flag_value    <= cfg_data;
        CFG_CONTROL: cfg.control_value <= cfg_data;
        default:     ;
      endcase
    end
  end

  // A word is taken whenever the result register is free or being emptied
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  hfcv_frame_core #(
    .INFO_CAP(INFO_CAP)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .hex_char (s_tdata),
    .last_char(s_tlast),
    .result   (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      out_word <= result;
    end
  end

  assign m_tdata = {7'd0, out_word};

endmodule
